[src/assert_macros.svh]
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  `ASSERT_AT(label, clk, rst_n, (ante) |-> (cons))

`endif

[src/pcf_pkg.sv]
// types, constants and functions of the png chunk framer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pcf_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

  localparam int unsigned StepW = 4;

  localparam logic [7:0] PngSig [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                        8'd13, 8'd10, 8'd26, 8'd10};

  typedef enum logic [1:0] {
    ACT_OPEN = 2'd0,
    ACT_DATA = 2'd1,
    ACT_SIG  = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CMD_SIG,
    CMD_OPEN,
    CMD_DATA,
    CMD_STRAY
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [30:0] chunk_length;
    logic [31:0] chunk_type;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       chunk_done;
    logic       run_last;
    logic       framing_error;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        err;
    logic        close;
    logic [30:0] length;
    logic [31:0] ctype;
    logic [7:0]  data;
  } cmd_t;

  function automatic logic [31:0] crc_fold(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

  // byte pos of a word, first byte most significant
  function automatic logic [7:0] word_byte(logic [31:0] w, logic [1:0] pos);
    return w[{~pos, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

[src/pcf_front.sv]
// front end: accepts input words, tracks chunk framing, issues commands
// depends on pcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcf_front import pcf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          cmd_valid_o,
  input  wire logic     cmd_ready_i,
  output cmd_t          cmd_o
);

  logic        open_q, open_d;
  logic [30:0] rem_q, rem_d;
  logic [30:0] rem_dec;
  logic        accept;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign rem_dec    = rem_q - 31'd1;

  always_comb begin
    open_d            = open_q;
    rem_d             = rem_q;
    cmd_valid_o       = 1'b0;
    cmd_o.kind        = CMD_SIG;
    cmd_o.err         = 1'b0;
    cmd_o.close       = 1'b0;
    cmd_o.length      = in_item_i.chunk_length;
    cmd_o.ctype       = in_item_i.chunk_type;
    cmd_o.data        = in_item_i.data_byte;
    case (in_item_i.action)
      ACT_OPEN: begin
        cmd_valid_o = in_valid_i;
        cmd_o.kind  = CMD_OPEN;
        cmd_o.err   = open_q;
        cmd_o.close = (in_item_i.chunk_length == 31'd0);
        if (accept) begin
          open_d = (in_item_i.chunk_length != 31'd0);
          rem_d  = in_item_i.chunk_length;
        end
      end
      ACT_DATA: begin
        cmd_valid_o = in_valid_i;
        if (!open_q) begin
          cmd_o.kind = CMD_STRAY;
          cmd_o.err  = 1'b1;
        end else begin
          cmd_o.kind  = CMD_DATA;
          cmd_o.close = (rem_dec == 31'd0);
          if (accept) begin
            rem_d  = rem_dec;
            open_d = (rem_dec != 31'd0);
          end
        end
      end
      ACT_SIG: begin
        cmd_valid_o = in_valid_i;
        cmd_o.kind  = CMD_SIG;
      end
      default: begin
        cmd_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      rem_q  <= '0;
    end else begin
      open_q <= open_d;
      rem_q  <= rem_d;
    end
  end

endmodule

`default_nettype wire

[src/pcf_queue.sv]
// short command queue between front and back
// depends on pcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcf_queue import pcf_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  output logic      ready_o,
  input  wire cmd_t data_i,
  output logic      valid_o,
  input  wire logic pop_i,
  output cmd_t      data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            slot_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[src/pcf_back.sv]
// back end: serialises commands into bytes and keeps the running crc
// depends on pcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcf_back import pcf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  output logic      cmd_pop_o,
  input  wire cmd_t cmd_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_item_t out_item_o
);

  logic [StepW-1:0] step_q, step_d, last_step;
  logic [31:0]      crc_q, crc_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic             fire;
  logic [31:0]      crc_out;
  logic [1:0]       pos;

  assign fire    = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign crc_out = ~crc_q;
  assign pos     = step_q[1:0];

  always_comb begin
    case (cmd_i.kind)
      CMD_SIG:  last_step = StepW'(7);
      CMD_OPEN: last_step = cmd_i.close ? StepW'(11) : StepW'(7);
      CMD_DATA: last_step = cmd_i.close ? StepW'(4) : StepW'(0);
      default:  last_step = StepW'(0);
    endcase
  end

  assign cmd_pop_o = fire && (step_q == last_step);

  always_comb begin
    crc_d               = crc_q;
    out_d               = out_q;
    out_d.chunk_done    = 1'b0;
    out_d.run_last      = (step_q == last_step);
    out_d.framing_error = cmd_i.err;
    case (cmd_i.kind)
      CMD_SIG: begin
        out_d.out_byte = PngSig[step_q[2:0]];
      end
      CMD_OPEN: begin
        if (step_q < StepW'(4)) begin
          out_d.out_byte = word_byte({1'b0, cmd_i.length}, pos);
        end else if (step_q < StepW'(8)) begin
          out_d.out_byte = word_byte(cmd_i.ctype, pos);
          crc_d = crc_fold((step_q == StepW'(4)) ? CrcInit : crc_q,
                           word_byte(cmd_i.ctype, pos));
        end else begin
          out_d.out_byte = word_byte(crc_out, pos);
          if (step_q == StepW'(11)) begin
            out_d.chunk_done = 1'b1;
            crc_d            = CrcInit;
          end
        end
      end
      CMD_DATA: begin
        if (step_q == '0) begin
          out_d.out_byte = cmd_i.data;
          crc_d          = crc_fold(crc_q, cmd_i.data);
        end else begin
          out_d.out_byte = word_byte(crc_out, pos - 2'd1);
          if (step_q == StepW'(4)) begin
            out_d.chunk_done = 1'b1;
            crc_d            = CrcInit;
          end
        end
      end
      default: begin
        out_d.out_byte = 8'd0;
      end
    endcase
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
      step_d      = cmd_pop_o ? '0 : step_q + StepW'(1);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        crc_q <= crc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

[src/png_chunk_framer_crc32.sv]
// png chunk framer with crc-32: top level
// depends on pcf_pkg, pcf_front, pcf_queue, pcf_back
//
// usage
//   input channel (in_valid_i / in_ready_o / in_item_i): one word per action,
//   open chunk, data byte or signature. output channel (out_valid_o /
//   out_ready_i / out_item_o): one stream byte per word with its flags.
//   a signature yields 8 bytes, an open 8 bytes (12 with an empty chunk),
//   a data byte 1 (5 when it closes the chunk with the crc), a stray data
//   byte a single flagged word, the unused action nothing.
//   the back end puts out one byte per cycle while the receiver does not stall, so
//   data bytes run at one per cycle and header bursts go out byte by byte; the crc
//   folds one byte a cycle. with an empty queue, a word passes the queue slot and then the output register.
//   the command queue holds QueueDepth words, so input keeps flowing while
//   a header burst is sent or the receiver stalls; when it fills, in_ready_o
//   drops until the back end frees a slot.
//   reset clears chunk state, the queue and the output valid flag; crc
//   returns to all ones.
`timescale 1ns / 1ps
`default_nettype none

module png_chunk_framer_crc32 import pcf_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_item_o
);

  logic cmd_valid, cmd_ready, head_valid, head_pop;
  cmd_t cmd, head;

  pcf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  pcf_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .ready_o (cmd_ready),
    .data_i  (cmd),
    .valid_o (head_valid),
    .pop_i   (head_pop),
    .data_o  (head)
  );

  pcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_pop_o   (head_pop),
    .cmd_i       (head),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

[src/pcf_checker.sv]
// port-level checks of the png chunk framer, bound to the top level
// depends on pcf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pcf_checker import pcf_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_item_t  in_item_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_o
);

  // stalled input word holds
  `ASSERT_AT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))

  // stalled output word holds
  `ASSERT_AT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))

  // a chunk always closes on the last word of its run
  `ASSERT_IMPL(a_done_last, clk_i, rst_ni, out_valid_o && out_item_o.chunk_done, out_item_o.run_last)

  // a run is sent without gaps
  `ASSERT_AT(a_run_gapless, clk_i, rst_ni, out_valid_o && out_ready_i && !out_item_o.run_last |=> out_valid_o)

endmodule

bind png_chunk_framer_crc32 pcf_checker u_pcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

[tb/png_chunk_framer_crc32_test.sv]
// self-checking testbench for png_chunk_framer_crc32: directed table, then random chunk traffic
// predicts the byte stream and crc-32 independently; needs pcf_pkg and the framer rtl
`timescale 1ns / 1ps

module png_chunk_framer_crc32_test;
  import pcf_pkg::*;

  localparam logic [31:0] CrcPolyR = 32'hEDB88320;
  localparam logic [63:0] SigWord  = 64'h89504E470D0A1A0A;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 20;

  typedef struct packed {
    in_item_t    item;
    logic        typed;
    logic [3:0]  n_typed;
    logic        typed_err;
    logic [63:0] typed_bytes;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  // predictor state
  logic [31:0] chunk_crc  = '1;
  logic [30:0] bytes_owed = '0;
  logic        in_chunk   = 1'b0;

  out_item_t stream_q [$];
  out_item_t burst_q [$];
  out_item_t typed_q [$];
  dir_row_t  dir_tab [$];
  out_item_t want_word;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int errors        = 0;

  png_chunk_framer_crc32 u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("png_chunk_framer_crc32_test failed");
    $finish;
  end

  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      r = {1'b0, r[31:1]} ^ (CrcPolyR & {32{r[0] ^ b[i]}});
    end
    return r;
  endfunction

  task automatic close_chunk(input logic err);
    logic [31:0] v;
    v = ~chunk_crc;
    for (int s = 3; s >= 0; s--) begin
      burst_q.push_back(out_item_t'{v[8*s +: 8], (s == 0), 1'b0, err});
    end
    in_chunk   = 1'b0;
    bytes_owed = '0;
    chunk_crc  = '1;
  endtask

  // stream bytes caused by one input word, with the chunk state updated
  task automatic expand_word(input in_item_t w);
    logic        err;
    logic [31:0] hdr;
    burst_q.delete();
    case (w.action)
      ACT_SIG: begin
        for (int i = 7; i >= 0; i--) begin
          burst_q.push_back(out_item_t'{SigWord[8*i +: 8], 1'b0, 1'b0, 1'b0});
        end
      end
      ACT_OPEN: begin
        err = in_chunk;
        hdr = {1'b0, w.chunk_length};
        for (int s = 3; s >= 0; s--) begin
          burst_q.push_back(out_item_t'{hdr[8*s +: 8], 1'b0, 1'b0, err});
        end
        chunk_crc = '1;
        for (int s = 3; s >= 0; s--) begin
          burst_q.push_back(out_item_t'{w.chunk_type[8*s +: 8], 1'b0, 1'b0, err});
          chunk_crc = crc32_byte(chunk_crc, w.chunk_type[8*s +: 8]);
        end
        if (w.chunk_length == '0) begin
          close_chunk(err);
        end else begin
          in_chunk   = 1'b1;
          bytes_owed = w.chunk_length;
        end
      end
      ACT_DATA: begin
        if (!in_chunk) begin
          burst_q.push_back(out_item_t'{8'd0, 1'b0, 1'b0, 1'b1});
        end else begin
          burst_q.push_back(out_item_t'{w.data_byte, 1'b0, 1'b0, 1'b0});
          chunk_crc  = crc32_byte(chunk_crc, w.data_byte);
          bytes_owed = bytes_owed - 31'd1;
          if (bytes_owed == '0) close_chunk(1'b0);
        end
      end
      default: begin
      end
    endcase
    if (burst_q.size() != 0) burst_q[burst_q.size() - 1].run_last = 1'b1;
  endtask

  task automatic send_word(input in_item_t w, input bit typed);
    bit took;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= w;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end
    expand_word(w);
    if (typed) burst_q = typed_q;
    foreach (burst_q[i]) stream_q.push_back(burst_q[i]);
    if (w.action != ACT_NONE) items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (stream_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  function automatic in_item_t rand_word();
    in_item_t    w;
    logic [31:0] r;
    r = $urandom;
    w.action       = r[1:0];
    r = $urandom;
    w.chunk_length = r[30:0];
    w.chunk_type   = $urandom;
    r = $urandom;
    w.data_byte    = r[7:0];
    return w;
  endfunction

  // mostly well-formed chunks with random content, some broken ones and noise
  task automatic random_traffic(input int n);
    int       stop_at;
    int       pick;
    int       len;
    in_item_t w;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      w = rand_word();
      if (pick < 8) begin
        w.action = ACT_SIG;
        send_word(w, 1'b0);
      end else if (pick < 78) begin
        len = (pick < 12) ? $urandom_range(12, 40) : $urandom_range(0, 10);
        w.action       = ACT_OPEN;
        w.chunk_length = 31'(len);
        send_word(w, 1'b0);
        for (int k = 0; k < len; k++) begin
          w = rand_word();
          w.action = ($urandom_range(0, 99) < 4) ? ACT_SIG : ACT_DATA;
          if (w.action == ACT_SIG) begin
            send_word(w, 1'b0);
            w.action = ACT_DATA;
          end
          send_word(w, 1'b0);
        end
      end else if (pick < 86) begin
        w.action = ACT_OPEN;
        send_word(w, 1'b0);
        len = $urandom_range(0, 4);
        for (int k = 0; k < len; k++) begin
          w = rand_word();
          w.action = ACT_DATA;
          send_word(w, 1'b0);
        end
      end else if (pick < 94) begin
        w.action = ACT_DATA;
        send_word(w, 1'b0);
      end else begin
        w.action = ACT_NONE;
        send_word(w, 1'b0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen   <= hold_reqs;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (stream_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got %h", $time, out_item_o);
      end else begin
        want_word = stream_q.pop_front();
        if (out_item_o !== want_word) begin
          errors++;
          $display("%0t: expected byte %h done %b last %b err %b, got byte %h done %b last %b err %b",
                   $time, want_word.out_byte, want_word.chunk_done, want_word.run_last,
                   want_word.framing_error, out_item_o.out_byte, out_item_o.chunk_done,
                   out_item_o.run_last, out_item_o.framing_error);
        end
      end
    end
  end

  function automatic dir_row_t dir_row(input action_e a, input logic [30:0] len,
                                       input logic [31:0] ty, input logic [7:0] db,
                                       input logic typed, input logic [3:0] n,
                                       input logic err, input logic [63:0] bytes);
    dir_row_t r;
    r.item.action       = a;
    r.item.chunk_length = len;
    r.item.chunk_type   = ty;
    r.item.data_byte    = db;
    r.typed             = typed;
    r.n_typed           = n;
    r.typed_err         = err;
    r.typed_bytes       = bytes;
    return r;
  endfunction

  initial begin
    dir_row_t r;

    // stray word straight after reset, unused action, bare signature
    dir_tab.push_back(dir_row(ACT_DATA, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 4'd1, 1'b1, 64'd0));
    dir_tab.push_back(dir_row(ACT_NONE, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 4'd0, 1'b0, 64'd0));
    dir_tab.push_back(dir_row(ACT_SIG, 31'd0, 32'd0, 8'd0, 1'b1, 4'd8, 1'b0, SigWord));
    // empty chunks
    dir_tab.push_back(dir_row(ACT_OPEN, 31'd0, 32'h4945_4E44, 8'd0, 1'b0, 4'd0, 1'b0, 64'd0));
    dir_tab.push_back(dir_row(ACT_OPEN, 31'd0, 32'h0000_0000, 8'd0, 1'b0, 4'd0, 1'b0, 64'd0));
    dir_tab.push_back(dir_row(ACT_OPEN, 31'd0, 32'hFFFF_FFFF, 8'hFF, 1'b0, 4'd0, 1'b0, 64'd0));
    // complete chunk with extreme data
    dir_tab.push_back(dir_row(ACT_OPEN, 31'd3, 32'h4944_4154, 8'd0, 1'b0, 4'd0, 1'b0, 64'd0));
    dir_tab.push_back(dir_row(ACT_DATA, 31'd0, 32'd0, 8'h00, 1'b0, 4'd0, 1'b0, 64'd0));
    dir_tab.push_back(dir_row(ACT_DATA, 31'd0, 32'd0, 8'hFF, 1'b0, 4'd0, 1'b0, 64'd0));
    dir_tab.push_back(dir_row(ACT_DATA, 31'd0, 32'd0, 8'hA5, 1'b0, 4'd0, 1'b0, 64'd0));
    // signature inside an open chunk
    dir_tab.push_back(dir_row(ACT_OPEN, 31'd2, 32'h7445_5874, 8'd0, 1'b0, 4'd0, 1'b0, 64'd0));
    dir_tab.push_back(dir_row(ACT_DATA, 31'd0, 32'd0, 8'h12, 1'b0, 4'd0, 1'b0, 64'd0));
    dir_tab.push_back(dir_row(ACT_SIG, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 4'd8, 1'b0,
                              SigWord));
    dir_tab.push_back(dir_row(ACT_DATA, 31'd0, 32'd0, 8'h34, 1'b0, 4'd0, 1'b0, 64'd0));
    // abandoned chunks
    dir_tab.push_back(dir_row(ACT_OPEN, 31'd5, 32'h1234_5678, 8'd0, 1'b0, 4'd0, 1'b0, 64'd0));
    dir_tab.push_back(dir_row(ACT_DATA, 31'd0, 32'd0, 8'h01, 1'b0, 4'd0, 1'b0, 64'd0));
    dir_tab.push_back(dir_row(ACT_OPEN, 31'd1, 32'h89AB_CDEF, 8'd0, 1'b0, 4'd0, 1'b0, 64'd0));
    dir_tab.push_back(dir_row(ACT_DATA, 31'd0, 32'd0, 8'h77, 1'b0, 4'd0, 1'b0, 64'd0));
    dir_tab.push_back(dir_row(ACT_OPEN, 31'h7FFF_FFFF, 32'hA5A5_A5A5, 8'd0, 1'b0, 4'd0, 1'b0,
                              64'd0));
    dir_tab.push_back(dir_row(ACT_DATA, 31'd0, 32'd0, 8'hAA, 1'b0, 4'd0, 1'b0, 64'd0));
    dir_tab.push_back(dir_row(ACT_NONE, 31'd0, 32'd0, 8'd0, 1'b1, 4'd0, 1'b0, 64'd0));
    dir_tab.push_back(dir_row(ACT_OPEN, 31'd0, 32'h5A5A_5A5A, 8'd0, 1'b0, 4'd0, 1'b0, 64'd0));
    dir_tab.push_back(dir_row(ACT_DATA, 31'd0, 32'd0, 8'h00, 1'b1, 4'd1, 1'b1, 64'd0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 26;
    recv_idle_pct = 78;
    foreach (dir_tab[j]) begin
      r = dir_tab[j];
      typed_q.delete();
      for (int i = 0; i < r.n_typed; i++) begin
        typed_q.push_back(out_item_t'{r.typed_bytes[63 - 8*i -: 8], 1'b0,
                                      (i == r.n_typed - 1), r.typed_err});
      end
      send_word(r.item, r.typed);
    end
    random_traffic(112);
    wait_drained();

    send_idle_pct = 78;
    recv_idle_pct = 26;
    hold_reqs++;
    random_traffic(120);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_reqs++;
    random_traffic(120);
    wait_drained();

    if (errors == 0) begin
      $display("png_chunk_framer_crc32_test passed");
    end else begin
      $display("png_chunk_framer_crc32_test failed");
    end
    $finish;
  end

endmodule
